@@ hw/rtl/msl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_pkg - shared types and constants for the Menger slice membership test
// Register indexes, reset values, coordinate widths and pipeline flag types.
// ----------------------------------------------------------------------------
package msl_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_INV_SCALE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_OFFSET = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_LEVELS = 2'd2;

   localparam logic [31:0] INV_SCALE_RESET    = 32'd65536;
   localparam logic [31:0] SLICE_OFFSET_RESET = 32'd0;
   localparam logic [3:0]  DEPTH_LEVELS_RESET = 4'd3;

   // scaled coordinate in Q.32, saturated to magnitude 2^47
   localparam int COORD_W = 49;
   // 4u = 2 + offset/2 + s in Q.32
   localparam int SUM_W   = 51;

   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] sz;
   } scaled_type;

   typedef struct packed {
      logic beyond_box;
      logic removed;
   } flag_type;

endpackage

@@ hw/rtl/msl_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_channels - request and response channel interfaces
// Valid/ready channels carrying the point and the membership verdict.
// ----------------------------------------------------------------------------
interface msl_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input point_z,
                 output ready);
   modport monitor (input valid, input ready, input point_x, input point_y,
                    input point_z);
endinterface

interface msl_rsp_if;
   logic valid;
   logic ready;
   logic outside_slice;
   logic beyond_box;

   modport source (output valid, output outside_slice, output beyond_box, input ready);
   modport sink (input valid, input outside_slice, input beyond_box, output ready);
   modport monitor (input valid, input ready, input outside_slice, input beyond_box);
endinterface

@@ hw/rtl/msl_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_scale - scale stage
// Multiplies each coordinate by the reciprocal scale and saturates to 2^47.
// ----------------------------------------------------------------------------
module msl_scale
   import msl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic signed [31:0] point_x,
   input  logic signed [31:0] point_y,
   input  logic signed [31:0] point_z,
   input  logic        [31:0] inv_scale,
   output logic               out_valid,
   input  logic               out_ready,
   output scaled_type         scaled
);

   localparam logic signed [64:0] SAT_POS = 65'sh0_0000_8000_0000_0000;
   localparam logic signed [64:0] SAT_NEG = -SAT_POS;

   logic       valid_ff;
   scaled_type scaled_ff;
   scaled_type scaled_in;

   function automatic logic signed [COORD_W-1:0] scale_sat(
      input logic signed [31:0] p,
      input logic        [31:0] s
   );
      logic signed [64:0] prod;
      prod = $signed({{33{p[31]}}, p}) * $signed({33'd0, s});
      if (prod > SAT_POS) begin
         prod = SAT_POS;
      end else if (prod < SAT_NEG) begin
         prod = SAT_NEG;
      end
      return prod[COORD_W-1:0];
   endfunction

   always_comb begin
      scaled_in.sx = scale_sat(point_x, inv_scale);
      scaled_in.sy = scale_sat(point_y, inv_scale);
      scaled_in.sz = scale_sat(point_z, inv_scale);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         scaled_ff <= scaled_in;
      end
   end

   assign out_valid = valid_ff;
   assign scaled    = scaled_ff;

endmodule

@@ hw/rtl/msl_project.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_project - slice projection stage
// Forms the four slice coordinates, runs the hypercube bound test and
// truncates each coordinate to the inner fraction width.
// ----------------------------------------------------------------------------
module msl_project
   import msl_pkg::*;
#(
   parameter int INNER_FRAC_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  scaled_type                 scaled,
   input  logic signed [31:0]         slice_offset,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [INNER_FRAC_BITS:0]   r_out [4],
   output flag_type                   flags
);

   localparam logic signed [SUM_W-1:0] HALF_FOUR = SUM_W'(64'sd1 <<< 33);
   localparam logic signed [SUM_W-1:0] FOUR_ONE  = SUM_W'(64'sd1 <<< 34);

   logic                        valid_ff;
   logic [INNER_FRAC_BITS:0]    r_ff [4];
   logic [INNER_FRAC_BITS:0]    r_in [4];
   flag_type                    flags_ff;
   flag_type                    flags_in;
   logic signed [SUM_W-1:0]     base;
   logic signed [SUM_W-1:0]     sx;
   logic signed [SUM_W-1:0]     sy;
   logic signed [SUM_W-1:0]     sz;
   logic signed [SUM_W-1:0]     w [4];
   logic [3:0]                  out_of_box;

   assign sx   = SUM_W'(scaled.sx);
   assign sy   = SUM_W'(scaled.sy);
   assign sz   = SUM_W'(scaled.sz);
   assign base = HALF_FOUR + (SUM_W'(slice_offset) <<< 15);

   assign w[0] = base + sx + sy - sz;
   assign w[1] = base - sx - sy - sz;
   assign w[2] = base + sx - sy + sz;
   assign w[3] = base - sx + sy + sz;

   genvar k;
   for (k = 0; k < 4; k++) begin : g_lane
      assign out_of_box[k] = (w[k] < 0) || (w[k] > FOUR_ONE);
      // inside the box w lies in [0, 2^34], so bits 34..0 hold it
      if (INNER_FRAC_BITS <= 34) begin : g_trunc
         assign r_in[k] = w[k][34 -: INNER_FRAC_BITS + 1];
      end else begin : g_widen
         assign r_in[k] = {w[k][34:0], {(INNER_FRAC_BITS - 34){1'b0}}};
      end
   end

   always_comb begin
      flags_in.beyond_box = |out_of_box;
      flags_in.removed    = 1'b0;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         r_ff     <= r_in;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = valid_ff;
   assign r_out     = r_ff;
   assign flags     = flags_ff;

endmodule

@@ hw/rtl/msl_level.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_level - one base-3 subdivision level
// Takes one ternary digit of each slice coordinate and, if LEVEL is below
// depth_levels, marks the point removed when two or more digits are 1.
// ----------------------------------------------------------------------------
module msl_level
   import msl_pkg::*;
#(
   parameter int INNER_FRAC_BITS = 24,
   parameter int LEVEL           = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [INNER_FRAC_BITS:0] r_in [4],
   input  flag_type                 flags_in,
   input  logic [3:0]               depth_levels,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [INNER_FRAC_BITS:0] r_out [4],
   output flag_type                 flags_out
);

   localparam int F = INNER_FRAC_BITS;

   logic             valid_ff;
   logic [F:0]       r_ff [4];
   logic [F:0]       r_next [4];
   flag_type         flags_ff;
   flag_type         flags_next;
   logic [F+2:0]     v [4];
   logic [3:0]       mid;
   logic [2:0]       mid_cnt;
   logic             active;

   genvar k;
   for (k = 0; k < 4; k++) begin : g_lane
      // v = 3r; digit is the integer part, remainder the fraction
      assign v[k]      = {2'b00, r_in[k]} + {1'b0, r_in[k], 1'b0};
      assign mid[k]    = (v[k][F+2:F] == 3'd1);
      assign r_next[k] = {1'b0, v[k][F-1:0]};
   end

   assign mid_cnt = 3'(mid[0]) + 3'(mid[1]) + 3'(mid[2]) + 3'(mid[3]);
   assign active  = (5'(LEVEL) < {1'b0, depth_levels});

   always_comb begin
      flags_next            = flags_in;
      flags_next.removed    = flags_in.removed || (active && (mid_cnt > 3'd1));
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         r_ff     <= r_next;
         flags_ff <= flags_next;
      end
   end

   assign out_valid = valid_ff;
   assign r_out     = r_ff;
   assign flags_out = flags_ff;

endmodule

@@ hw/rtl/menger_4d_slice_membership_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// menger_4d_slice_membership_test - 4D Menger sponge slice membership test
// Accepts one Q16.16 point per cycle unless stalled; reports whether it lies
// outside the sponge slice and whether the hypercube bound test rejected it.
// ----------------------------------------------------------------------------
// Fully pipelined over MAX_DEPTH + 2 register stages: one point enters every
// cycle unless a held-off response has backed up every stage, and its verdict
// passes the scale, projection and level registers in order; a held-off
// response delays it further. One stage holds the three scale multipliers,
// one forms the slice coordinates and bound test, and one stage per
// subdivision level extracts a ternary digit of all four coordinates.
// Each stage has its own valid bit and accepts when it is empty or its
// successor accepts, so bubbles fill while a response waits. Configuration
// registers are used live and must be written while no request is in flight.
// ----------------------------------------------------------------------------
module menger_4d_slice_membership_test
   import msl_pkg::*;
#(
   parameter int MAX_DEPTH       = 8,
   parameter int INNER_FRAC_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   msl_req_if.sink                req_ch,
   msl_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [31:0] inv_scale_ff;
   logic [31:0] slice_offset_ff;
   logic [3:0]  depth_levels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_scale_ff    <= INV_SCALE_RESET;
         slice_offset_ff <= SLICE_OFFSET_RESET;
         depth_levels_ff <= DEPTH_LEVELS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INV_SCALE:    inv_scale_ff    <= csr_wdata;
            CSR_SLICE_OFFSET: slice_offset_ff <= csr_wdata;
            CSR_DEPTH_LEVELS: depth_levels_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   logic                     s1_valid;
   logic                     s1_ready;
   scaled_type               s1_scaled;

   logic                     lvl_valid [MAX_DEPTH+1];
   logic                     lvl_ready [MAX_DEPTH+1];
   logic [INNER_FRAC_BITS:0] lvl_r     [MAX_DEPTH+1][4];
   flag_type                 lvl_flags [MAX_DEPTH+1];

   msl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .point_x   (req_ch.point_x),
      .point_y   (req_ch.point_y),
      .point_z   (req_ch.point_z),
      .inv_scale (inv_scale_ff),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .scaled    (s1_scaled)
   );

   msl_project #(
      .INNER_FRAC_BITS (INNER_FRAC_BITS)
   ) u_project (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid),
      .in_ready     (s1_ready),
      .scaled       (s1_scaled),
      .slice_offset ($signed(slice_offset_ff)),
      .out_valid    (lvl_valid[0]),
      .out_ready    (lvl_ready[0]),
      .r_out        (lvl_r[0]),
      .flags        (lvl_flags[0])
   );

   genvar i;
   for (i = 0; i < MAX_DEPTH; i++) begin : g_level
      msl_level #(
         .INNER_FRAC_BITS (INNER_FRAC_BITS),
         .LEVEL           (i)
      ) u_level (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (lvl_valid[i]),
         .in_ready     (lvl_ready[i]),
         .r_in         (lvl_r[i]),
         .flags_in     (lvl_flags[i]),
         .depth_levels (depth_levels_ff),
         .out_valid    (lvl_valid[i+1]),
         .out_ready    (lvl_ready[i+1]),
         .r_out        (lvl_r[i+1]),
         .flags_out    (lvl_flags[i+1])
      );
   end

   // last level stage doubles as the response register
   assign lvl_ready[MAX_DEPTH] = rsp_ch.ready;
   assign rsp_ch.valid         = lvl_valid[MAX_DEPTH];
   assign rsp_ch.beyond_box    = lvl_flags[MAX_DEPTH].beyond_box;
   assign rsp_ch.outside_slice = lvl_flags[MAX_DEPTH].beyond_box
                               | lvl_flags[MAX_DEPTH].removed;

endmodule

@@ hw/rtl/msl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_checker - port-level checks for the slice membership test
// Watches the response channel and reset behavior from the top-level ports.
// ----------------------------------------------------------------------------
module msl_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_outside_slice,
   input logic rsp_beyond_box
);

   // hold a stalled response
   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_outside_slice) && $stable(rsp_beyond_box))
      else $error("response payload changed while stalled");

   a_box_implies_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beyond_box |-> rsp_outside_slice)
      else $error("box rejection without outside verdict");

   // an empty or draining output stage lets every stage advance
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request refused while the pipeline can advance");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind menger_4d_slice_membership_test msl_checker u_msl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_outside_slice (rsp_ch.outside_slice),
   .rsp_beyond_box    (rsp_ch.beyond_box)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the 4D Menger sponge slice membership test
// Streams Q16.16 points through the block under random source and sink
// stalls, predicts each verdict in fixed point from a local copy of the
// configuration registers and compares it with the response, field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import msl_pkg::*;

   localparam int     MAX_DEPTH       = 8;
   localparam int     INNER_FRAC_BITS = 24;
   localparam longint FOUR_ONE        = 64'sd1 << 34;
   localparam longint COORD_SAT       = 64'sd1 << 47;
   localparam int     LONG_HOLD       = 300;
   localparam int     WATCHDOG_LIMIT  = 4000;

   typedef struct packed {
      logic outside_slice;
      logic beyond_box;
   } verdict_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   msl_req_if req_ch ();
   msl_rsp_if rsp_ch ();

   // predictor copy of the configuration registers
   logic [31:0]        pred_inv_scale = INV_SCALE_RESET;
   logic signed [31:0] pred_offset    = SLICE_OFFSET_RESET;
   logic [3:0]         pred_depth     = DEPTH_LEVELS_RESET;

   point_type   point_q [$];
   verdict_type verdict_q [$];

   bit idle_on       = 1'b0;
   bit long_hold_req = 1'b0;
   int send_gap      = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int rsp_count     = 0;
   int errors        = 0;

   menger_4d_slice_membership_test #(
      .MAX_DEPTH       (MAX_DEPTH),
      .INNER_FRAC_BITS (INNER_FRAC_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic verdict_type predict_verdict(logic signed [31:0] px,
                                                   logic signed [31:0] py,
                                                   logic signed [31:0] pz);
      longint      coord [3];
      longint      scaled [3];
      longint      quad [4];
      longint      base;
      logic [63:0] frac [4];
      logic [63:0] tripled;
      logic [63:0] digit;
      int          levels;
      int          mids;
      verdict_type res;
      coord[0] = longint'(px);
      coord[1] = longint'(py);
      coord[2] = longint'(pz);
      for (int k = 0; k < 3; k++) begin
         scaled[k] = coord[k] * longint'({32'd0, pred_inv_scale});
         if (scaled[k] > COORD_SAT) scaled[k] = COORD_SAT;
         else if (scaled[k] < -COORD_SAT) scaled[k] = -COORD_SAT;
      end
      // four times the slice coordinate, Q.32
      base    = FOUR_ONE / 2 + longint'(pred_offset) * 32768;
      quad[0] = base + scaled[0] + scaled[1] - scaled[2];
      quad[1] = base - scaled[0] - scaled[1] - scaled[2];
      quad[2] = base + scaled[0] - scaled[1] + scaled[2];
      quad[3] = base - scaled[0] + scaled[1] + scaled[2];
      res.beyond_box = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (quad[k] < 0 || quad[k] > FOUR_ONE) res.beyond_box = 1'b1;
      end
      res.outside_slice = res.beyond_box;
      if (!res.beyond_box) begin
         for (int k = 0; k < 4; k++) begin
            frac[k] = quad[k];
            frac[k] = frac[k] >> (34 - INNER_FRAC_BITS);
         end
         levels = (int'(pred_depth) > MAX_DEPTH) ? MAX_DEPTH : int'(pred_depth);
         for (int lv = 0; lv < levels; lv++) begin
            mids = 0;
            for (int k = 0; k < 4; k++) begin
               tripled = frac[k] * 64'd3;
               digit   = tripled >> INNER_FRAC_BITS;
               frac[k] = tripled - (digit << INNER_FRAC_BITS);
               if (digit == 64'd1) mids++;
            end
            if (mids > 1) res.outside_slice = 1'b1;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t MISMATCH %s", $time, msg);
      errors++;
   endtask

   // request driver: hold the payload until accepted, idle in bursts
   always @(posedge clock) begin : drive_req
      point_type pt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (point_q.size() > 0 && idle_on && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 12);
            req_ch.valid <= 1'b0;
         end else if (point_q.size() > 0) begin
            pt = point_q.pop_front();
            req_ch.point_x <= pt.x;
            req_ch.point_y <= pt.y;
            req_ch.point_z <= pt.z;
            req_ch.valid   <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response sink: random stalls plus one long hold-off to back up the pipe
   always @(posedge clock) begin : drain_rsp
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(0, 12);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // compare before predicting so a same-edge request never meets its own response
   always @(posedge clock) begin : check_rsp
      verdict_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_count++;
            if (verdict_q.size() == 0) begin
               report_mismatch($sformatf("response %0d with no request outstanding",
                                         rsp_count));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_ch.outside_slice !== want.outside_slice)
                  report_mismatch($sformatf("response %0d outside_slice %b, expected %b",
                                            rsp_count, rsp_ch.outside_slice,
                                            want.outside_slice));
               if (rsp_ch.beyond_box !== want.beyond_box)
                  report_mismatch($sformatf("response %0d beyond_box %b, expected %b",
                                            rsp_count, rsp_ch.beyond_box, want.beyond_box));
            end
         end
         if (req_ch.valid && req_ch.ready)
            verdict_q.push_back(predict_verdict(req_ch.point_x, req_ch.point_y,
                                                req_ch.point_z));
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_INV_SCALE:    pred_inv_scale = data;
         CSR_SLICE_OFFSET: pred_offset    = data;
         CSR_DEPTH_LEVELS: pred_depth     = data[3:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [31:0] inv, input logic [31:0] offset,
                               input logic [3:0] depth);
      write_csr(CSR_INV_SCALE, inv);
      write_csr(CSR_SLICE_OFFSET, offset);
      write_csr(CSR_DEPTH_LEVELS, {28'd0, depth});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sample at the falling edge so the check never races the handshakes
   task automatic wait_drained();
      do @(negedge clock);
      while (point_q.size() != 0 || req_ch.valid || verdict_q.size() != 0);
   endtask

   // mostly points near the box for the current scale, some full-range noise
   function automatic logic signed [31:0] rand_coord(int unsigned reach);
      logic [31:0] pick;
      if ($urandom_range(0, 4) == 0) return $urandom();
      pick = $urandom_range(0, 2 * reach);
      return pick - reach;
   endfunction

   task automatic run_points(int count, bit idling, bit long_hold);
      longint unsigned span;
      int unsigned     reach;
      point_type       pt;
      span = (pred_inv_scale == 0) ? (64'd1 << 30) : (64'd5 << 30) / pred_inv_scale;
      if (span < 1) span = 1;
      if (span > (64'd1 << 30)) span = 64'd1 << 30;
      reach = 32'(span);
      @(negedge clock);
      idle_on       = idling;
      long_hold_req = long_hold;
      repeat (count) begin
         pt.x = rand_coord(reach);
         pt.y = rand_coord(reach);
         pt.z = rand_coord(reach);
         point_q.push_back(pt);
      end
      wait_drained();
   endtask

   task automatic push_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
      point_type pt;
      pt.x = x;
      pt.y = y;
      pt.z = z;
      point_q.push_back(pt);
   endtask

   initial begin : stimulus
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed points at the reset configuration
      @(negedge clock);
      idle_on = 1'b1;
      push_point(32'd0, 32'd0, 32'd0);
      push_point(32'd65536, 32'd65536, 32'd0);           // one coordinate at one
      push_point(-32'sd65536, -32'sd65536, 32'd0);
      push_point(32'd0, 32'd0, -32'sd131072);            // coordinates at zero and one
      push_point(32'd43690, 32'd43690, 32'd43690);
      push_point(32'd1, 32'd0, 32'd0);
      push_point(32'hFFFFFFFF, 32'd0, 32'd0);
      push_point(32'd0, 32'd131072, 32'd0);              // slice coordinates on the box boundary
      push_point(32'd21845, -32'sd21845, 32'd7281);
      push_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      push_point(32'h80000000, 32'h80000000, 32'h80000000);
      push_point(32'h80000000, 32'h7FFFFFFF, 32'd0);
      push_point(32'h7FFFFFFF, 32'h80000000, 32'h55555555);
      push_point(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
      wait_drained();

      apply_config(32'd65536, 32'd0, 4'd3);
      run_points(80, 1'b1, 1'b1);
      apply_config(32'd65536, -32'sd262144, 4'd8);
      run_points(80, 1'b1, 1'b0);
      apply_config(32'd32768, 32'd131072, 4'd0);       // depth zero, no idling
      run_points(80, 1'b0, 1'b0);
      apply_config(32'd0, 32'd0, 4'd2);                // zero scale
      run_points(40, 1'b1, 1'b0);
      apply_config(32'hFFFFFFFF, 32'h7FFFFFFF, 4'd15); // depth above maximum
      run_points(40, 1'b1, 1'b0);
      apply_config(32'd1, 32'h80000000, 4'd8);
      run_points(40, 1'b1, 1'b0);
      repeat (4) begin
         apply_config($urandom_range(16384, 262144),
                      $urandom_range(0, 2 * 294912) - 294912,
                      4'($urandom_range(0, 15)));
         run_points(80, 1'b1, 1'b0);
      end
      apply_config(32'd131072, 32'd65536, 4'd5);
      run_points(80, 1'b0, 1'b0);

      repeat (2 * MAX_DEPTH + 4) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
